// ===== sv/gbv_pkg.sv =====
// gbv_pkg: shared types, kernel weights and divider constants for the gaussian blur block
// no dependencies; used by every module of the block but gbv_ram
package gbv_pkg;

    localparam int WIN         = 5;
    localparam int LINE_STORES = 4;
    localparam int K3_OFF      = WIN - 3;
    localparam int PIX_W       = 8;
    localparam int ROW_SUM_W   = 15;
    localparam int SUM_W       = 17;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;
    localparam int DIV3_SHIFT  = 4;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int FW_W        = 11;
    localparam int FH_W        = 12;

    // ceil(2^26 / 273), exact for every sum below 2^17
    localparam logic [RECIP_W-1:0] RECIP_273 = 18'd245821;

    localparam logic [2:0] SIZE5_M1 = 3'd4;
    localparam logic [2:0] SIZE3_M1 = 3'd2;

    localparam logic [5:0] KERN5 [WIN*WIN] = '{
        6'd1,  6'd4,  6'd7,  6'd4,  6'd1,
        6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
        6'd7,  6'd26, 6'd41, 6'd26, 6'd7,
        6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
        6'd1,  6'd4,  6'd7,  6'd4,  6'd1
    };

    localparam logic [5:0] KERN3 [9] = '{
        6'd1, 6'd2, 6'd1,
        6'd2, 6'd4, 6'd2,
        6'd1, 6'd2, 6'd1
    };

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [WIN-1:0][WIN-1:0] t_window;

    typedef struct packed {
        logic            five;
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef struct packed {
        logic last;
        t_pix pixel;
    } t_result;

endpackage

// ===== sv/gbv_ram.sv =====
// gbv_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module gbv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gbv_line_window.sv =====
// gbv_line_window: column/row counters, line store ram and the 5x5 window registers
// depends on gbv_pkg and gbv_ram
module gbv_line_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  gbv_pkg::t_pix    i_pixel,
    input  gbv_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output gbv_pkg::t_tag    o_tag,
    output gbv_pkg::t_window o_window
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > gbv_pkg::FW_W) ? CW + 1 : gbv_pkg::FW_W;
    localparam int SW = gbv_pkg::LINE_STORES * gbv_pkg::PIX_W;
    localparam int FH = gbv_pkg::FH_W;

    logic [CW-1:0]    r_col, n_col;
    logic [FH-1:0]    r_row, n_row;
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_last;
    gbv_pkg::t_pix    r_s1_px;
    logic [CW-1:0]    r_s1_col;
    gbv_pkg::t_window r_win;
    gbv_pkg::t_tag    r_tag;

    logic [EW-1:0]    fw_ext, w_eff, col_ext;
    logic [FH-1:0]    h_eff;
    logic [2:0]       size_m1;
    logic             col_end, row_end, last;
    logic [SW-1:0]    rdata;
    gbv_pkg::t_pix    fresh [gbv_pkg::WIN];

    always_comb begin
        fw_ext  = EW'(i_cfg.frame_width);
        if (fw_ext < EW'(3)) begin
            w_eff = EW'(3);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        h_eff   = (i_cfg.frame_height < FH'(3)) ? FH'(3) : i_cfg.frame_height;
        size_m1 = i_cfg.five ? gbv_pkg::SIZE5_M1 : gbv_pkg::SIZE3_M1;
        col_ext = EW'(r_col);
        col_end = (col_ext + EW'(1)) >= w_eff;
        row_end = ((FH+1)'(r_row) + (FH+1)'(1)) >= (FH+1)'(h_eff);
        o_emit  = (col_ext >= EW'(size_m1)) && (r_row >= FH'(size_m1));
        last    = col_end && row_end;
        n_col   = r_col;
        n_row   = r_row;
        if (i_accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + FH'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_tag      <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= i_accept;
            r_tag.valid <= r_s1_valid && r_s1_emit;
            r_tag.last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_emit <= o_emit;
            r_s1_last <= last;
            r_s1_px   <= i_pixel;
            r_s1_col  <= r_col;
        end
    end

    // store k sits in byte k; the write shifts every store down one row
    gbv_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({rdata[SW-gbv_pkg::PIX_W-1:0], r_s1_px}),
        .i_re    (i_accept),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int rr = 0; rr < gbv_pkg::LINE_STORES; rr++) begin
            fresh[rr] = rdata[(gbv_pkg::LINE_STORES-1-rr)*gbv_pkg::PIX_W +: gbv_pkg::PIX_W];
        end
        fresh[gbv_pkg::WIN-1] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int r = 0; r < gbv_pkg::WIN; r++) begin
                for (int c = 0; c < gbv_pkg::WIN-1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                r_win[r][gbv_pkg::WIN-1] <= fresh[r];
            end
        end
    end

    assign o_tag    = r_tag;
    assign o_window = r_win;

endmodule

// ===== sv/gbv_kernel.sv =====
// gbv_kernel: weighted window sum and division, three register stages
// depends on gbv_pkg
module gbv_kernel (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gbv_pkg::t_tag    i_tag,
    input  gbv_pkg::t_window i_window,
    input  logic             i_five,
    output gbv_pkg::t_tag    o_tag,
    output gbv_pkg::t_pix    o_pixel
);

    localparam int RW = gbv_pkg::ROW_SUM_W;
    localparam int SW = gbv_pkg::SUM_W;
    localparam int PW = gbv_pkg::PROD_W;

    logic [RW-1:0] n_row_sum [gbv_pkg::WIN];
    logic [RW-1:0] r_row_sum [gbv_pkg::WIN];
    gbv_pkg::t_tag r_a_tag;
    logic [SW-1:0] n_total, r_total;
    gbv_pkg::t_tag r_b_tag;
    logic [PW-1:0] prod;
    gbv_pkg::t_pix n_pix, r_pix;
    gbv_pkg::t_tag r_c_tag;

    // row sums, constant weights only
    always_comb begin
        for (int i = 0; i < gbv_pkg::WIN; i++) begin
            n_row_sum[i] = '0;
            for (int j = 0; j < gbv_pkg::WIN; j++) begin
                if (i_five) begin
                    n_row_sum[i] = n_row_sum[i] + RW'(i_window[i][j])
                                 * RW'(gbv_pkg::KERN5[i*gbv_pkg::WIN+j]);
                end else if (i >= gbv_pkg::K3_OFF && j >= gbv_pkg::K3_OFF) begin
                    n_row_sum[i] = n_row_sum[i] + RW'(i_window[i][j])
                                 * RW'(gbv_pkg::KERN3[(i-gbv_pkg::K3_OFF)*3
                                                      + (j-gbv_pkg::K3_OFF)]);
                end
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int i = 0; i < gbv_pkg::WIN; i++) begin
            n_total = n_total + SW'(r_row_sum[i]);
        end
    end

    assign prod  = PW'(r_total) * PW'(gbv_pkg::RECIP_273);
    assign n_pix = i_five ? prod[gbv_pkg::RECIP_SHIFT +: gbv_pkg::PIX_W]
                          : r_total[gbv_pkg::DIV3_SHIFT +: gbv_pkg::PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_sum <= n_row_sum;
        r_total   <= n_total;
        r_pix     <= n_pix;
    end

    assign o_tag   = r_c_tag;
    assign o_pixel = r_pix;

endmodule

// ===== sv/gbv_out_fifo.sv =====
// gbv_out_fifo: small result queue between the kernel pipeline and the output stream
// depends on gbv_pkg
module gbv_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbv_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output gbv_pkg::t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbv_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== sv/gaussian_blur_valid_window_top.sv =====
// gaussian_blur_valid_window_top: streaming 3x3 / 5x5 gaussian blur, valid region only
// depends on gbv_pkg, gbv_line_window, gbv_kernel, gbv_out_fifo (gbv_ram below them)
//
// usage
//   s_axis carries one 8-bit pixel per request in raster order; m_axis returns one
//   blurred pixel per fully covered window, tlast high on the frame's last result.
//   the apb port holds the kernel select (0x0), frame width (0x4) and height (0x8);
//   write it only while the stream is idle.
//   a pixel is taken every clock while s_axis_tready is high. its result passes the
//   line ram read, window shift, row sums, total, divide and queue write in turn
//   before it is valid on m_axis.
//   results wait in an output queue of FIFO_DEPTH entries; s_axis_tready drops
//   only when the queue plus the pipeline hold FIFO_DEPTH results, so a stalled
//   receiver blocks the input before the queue can overflow, and nothing is lost.
//   reset clears counters, queue and config registers (kernel 3x3, 640 x 480); the line
//   ram is not cleared and needs no clearing pass, since no result reads an
//   entry that the current frame has not written.
module gaussian_blur_valid_window_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int FIFO_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] pixel_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] pixel_out
    output logic                        m_axis_tlast,   // frame_done
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbv_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbv_pkg::DATA_W-1:0]  pwdata,
    output logic [gbv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

    logic                       r_five;
    logic [gbv_pkg::FW_W-1:0]   r_width;
    logic [gbv_pkg::FH_W-1:0]   r_height;
    logic [PEND_W-1:0]          r_pend, n_pend;

    gbv_pkg::t_cfg    cfg;
    gbv_pkg::t_tag    win_tag, ker_tag;
    gbv_pkg::t_window window;
    gbv_pkg::t_pix    ker_pix;
    gbv_pkg::t_result push_data, out_data;
    logic             accept, emit, pop, wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_five   <= 1'b0;
            r_width  <= 11'd640;
            r_height <= 12'd480;
        end else if (wr_en) begin
            case (reg_idx)
                gbv_pkg::REG_MODE:   r_five   <= pwdata[0];
                gbv_pkg::REG_WIDTH:  r_width  <= pwdata[gbv_pkg::FW_W-1:0];
                gbv_pkg::REG_HEIGHT: r_height <= pwdata[gbv_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gbv_pkg::REG_MODE:   prdata = gbv_pkg::DATA_W'(r_five);
            gbv_pkg::REG_WIDTH:  prdata = gbv_pkg::DATA_W'(r_width);
            gbv_pkg::REG_HEIGHT: prdata = gbv_pkg::DATA_W'(r_height);
            default:             prdata = '0;
        endcase
    end

    assign cfg.five         = r_five;
    assign cfg.frame_width  = r_width;
    assign cfg.frame_height = r_height;

    // results promised but not yet delivered
    assign s_axis_tready = (r_pend < PEND_W'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_pend = r_pend;
        if ((accept && emit) && !pop) begin
            n_pend = r_pend + PEND_W'(1);
        end else if (!(accept && emit) && pop) begin
            n_pend = r_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    gbv_line_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_cfg    (cfg),
        .o_emit   (emit),
        .o_tag    (win_tag),
        .o_window (window)
    );

    gbv_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (win_tag),
        .i_window (window),
        .i_five   (r_five),
        .o_tag    (ker_tag),
        .o_pixel  (ker_pix)
    );

    assign push_data.last  = ker_tag.last;
    assign push_data.pixel = ker_pix;

    gbv_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ker_tag.valid),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data)
    );

    assign m_axis_tdata = out_data.pixel;
    assign m_axis_tlast = out_data.last;

endmodule

// ===== sv/gbv_checker.sv =====
// gbv_checker: port-level assertions for the gaussian blur top level, with its bind
// depends on gbv_pkg and gaussian_blur_valid_window_top
module gbv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [7:0]                  m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [gbv_pkg::ADDR_W-1:0]  paddr,
    input logic [gbv_pkg::DATA_W-1:0]  pwdata,
    input logic [gbv_pkg::DATA_W-1:0]  prdata,
    input logic                        pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // with the output queue empty the input is never blocked
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while no result waits");

    // a result first becomes takeable only after its pixel request was accepted
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 6))
        else $error("result without pixel request six cycles earlier");

    // width register reads back what was written
    a_width_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr == 4'd4)
        ##1 (psel && !pwrite && paddr == 4'd4)
        |-> prdata[gbv_pkg::FW_W-1:0] == $past(pwdata[gbv_pkg::FW_W-1:0]))
        else $error("width register readback mismatch");

endmodule

bind gaussian_blur_valid_window_top gbv_checker u_gbv_checker (.*);

// ===== verif/gaussian_blur_valid_window_top_tb.sv =====
// gaussian_blur_valid_window_top_tb: self-checking bench for the streaming gaussian blur block
// streams frames on s_axis, sets kernel and frame size over apb, checks every m_axis result
// depends on gbv_pkg and gaussian_blur_valid_window_top
module gaussian_blur_valid_window_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_COLS     = 1024;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_SLACK  = 8;
    localparam int unsigned END_SETTLE   = 20;
    localparam int unsigned RANDOM_ITEMS = 780;
    localparam int unsigned QUIET_ITEMS  = 200;

    class blur_scoreboard;
        gbv_pkg::t_pix              line_mem [gbv_pkg::LINE_STORES][MAX_COLS];
        gbv_pkg::t_pix              win [gbv_pkg::WIN][gbv_pkg::WIN];
        int unsigned                col_cnt;
        int unsigned                row_cnt;
        bit                         five;
        logic [gbv_pkg::FW_W-1:0]   width_reg;
        logic [gbv_pkg::FH_W-1:0]   height_reg;
        gbv_pkg::t_result           blurred_q [$];
        int unsigned                errors;

        function new();
            for (int k = 0; k < gbv_pkg::LINE_STORES; k++)
                for (int c = 0; c < MAX_COLS; c++) line_mem[k][c] = '0;
            for (int i = 0; i < gbv_pkg::WIN; i++)
                for (int j = 0; j < gbv_pkg::WIN; j++) win[i][j] = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            five       = 1'b0;
            width_reg  = (gbv_pkg::FW_W)'(640);
            height_reg = (gbv_pkg::FH_W)'(480);
            errors     = 0;
        endfunction

        function void write_reg(gbv_pkg::t_reg_idx idx, logic [gbv_pkg::DATA_W-1:0] value);
            case (idx)
                gbv_pkg::REG_MODE:   five = value[0];
                gbv_pkg::REG_WIDTH:  width_reg = value[gbv_pkg::FW_W-1:0];
                gbv_pkg::REG_HEIGHT: height_reg = value[gbv_pkg::FH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_COLS) w = MAX_COLS;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < 3) h = 3;
            return h;
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        function int unsigned pending();
            return blurred_q.size();
        endfunction

        // symmetric kernel: weight depends on distance from the nearest edge
        function int unsigned weight(int unsigned size, int unsigned i, int unsigned j);
            int unsigned a;
            int unsigned b;
            int unsigned t;
            if (size == 3) return ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
            a = (i > 2) ? 4 - i : i;
            b = (j > 2) ? 4 - j : j;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            case (a * 3 + b)
                0: return 1;
                1: return 4;
                2: return 7;
                4: return 16;
                5: return 26;
                default: return 41;
            endcase
        endfunction

        function void note_pixel(gbv_pkg::t_pix px);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            int unsigned      size;
            int unsigned      sum;
            gbv_pkg::t_pix    fresh [gbv_pkg::WIN];
            gbv_pkg::t_result res;
            w    = eff_width();
            h    = eff_height();
            c    = (col_cnt >= MAX_COLS) ? 0 : col_cnt;
            r    = row_cnt;
            size = five ? 5 : 3;
            for (int k = 0; k < gbv_pkg::LINE_STORES; k++)
                fresh[k] = line_mem[gbv_pkg::LINE_STORES-1-k][c];
            fresh[gbv_pkg::WIN-1] = px;
            for (int i = 0; i < gbv_pkg::WIN; i++) begin
                for (int j = 0; j < gbv_pkg::WIN - 1; j++) win[i][j] = win[i][j+1];
                win[i][gbv_pkg::WIN-1] = fresh[i];
            end
            for (int k = gbv_pkg::LINE_STORES - 1; k > 0; k--) line_mem[k][c] = line_mem[k-1][c];
            line_mem[0][c] = px;
            if (c + 1 >= size && r + 1 >= size) begin
                sum = 0;
                for (int i = 0; i < size; i++)
                    for (int j = 0; j < size; j++)
                        sum += win[gbv_pkg::WIN-size+i][gbv_pkg::WIN-size+j]
                               * weight(size, i, j);
                res.pixel = (size == 5) ? gbv_pkg::t_pix'(sum / 273)
                                        : gbv_pkg::t_pix'(sum / 16);
                res.last  = (c + 1 >= w) && (r + 1 >= h);
                blurred_q.push_back(res);
            end
            if (c + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        function void check_result(gbv_pkg::t_pix px, logic last);
            gbv_pkg::t_result want;
            if (blurred_q.size() == 0) begin
                $error("unexpected result: pixel_out %0d frame_done %0b", px, last);
                errors++;
            end else begin
                want = blurred_q.pop_front();
                if (px !== want.pixel) begin
                    $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, px);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("frame_done mismatch: expected %0b, actual %0b", want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [7:0]                  m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [gbv_pkg::ADDR_W-1:0]  paddr = '0;
    logic [gbv_pkg::DATA_W-1:0]  pwdata = '0;
    logic [gbv_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    blur_scoreboard sb;
    int unsigned    cycle_cnt = 0;
    int unsigned    sent = 0;
    int unsigned    stall_left = 0;
    int unsigned    calm_left = 0;
    bit             quiet = 1'b0;
    bit             gaps_on = 1'b1;

    gaussian_blur_valid_window_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // receiver backpressure: stall bursts mixed with calm stretches
    always @(negedge i_clk) begin
        if (quiet) begin
            m_axis_tready = 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else if (calm_left > 0) begin
            m_axis_tready = 1'b1;
            calm_left--;
        end else begin
            case ($urandom_range(0, 7))
                0: begin
                    m_axis_tready = 1'b1;
                    calm_left = $urandom_range(20, 200);
                end
                1, 2: begin
                    m_axis_tready = 1'b0;
                    stall_left = $urandom_range(1, 14) - 1;
                end
                default: m_axis_tready = 1'b1;
            endcase
        end
    end

    function automatic gbv_pkg::t_pix pick_pixel(int unsigned style);
        case (style)
            0: return 8'hFF;
            1: return 8'h00;
            2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return gbv_pkg::t_pix'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input gbv_pkg::t_pix px);
        s_axis_tdata  = px;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(px);
        sent++;
        @(negedge i_clk);
        if (!quiet && gaps_on && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    task automatic send_rest_of_frame(input int unsigned style);
        do send_pixel(pick_pixel(style)); while (!sb.at_frame_start());
    endtask

    // hold the request side until every blurred pixel is out and the pipeline is empty
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic write_reg(input gbv_pkg::t_reg_idx idx,
                             input logic [gbv_pkg::DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_frame(input bit mode5, input int unsigned w, input int unsigned h);
        drain_results();
        write_reg(gbv_pkg::REG_MODE, ($urandom & ~32'h1) | mode5);
        write_reg(gbv_pkg::REG_WIDTH, ($urandom & ~32'h7FF) | w);
        write_reg(gbv_pkg::REG_HEIGHT, ($urandom & ~32'hFFF) | h);
    endtask

    // width may only grow at a frame boundary, so no line ram entry is read unwritten
    task automatic reconfigure();
        int unsigned w;
        int unsigned h;
        bit          at_start;
        drain_results();
        at_start = sb.at_frame_start();
        if ($urandom_range(0, 1))
            write_reg(gbv_pkg::REG_MODE, ($urandom & ~32'h1) | $urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            if (at_start || w <= sb.eff_width())
                write_reg(gbv_pkg::REG_WIDTH, ($urandom & ~32'h7FF) | w);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0, 1: h = $urandom_range(0, 2);
                2:    h = $urandom_range(9, 20);
                default: h = $urandom_range(3, 8);
            endcase
            write_reg(gbv_pkg::REG_HEIGHT, ($urandom & ~32'hFFF) | h);
        end
    endtask

    initial begin
        int unsigned target;
        sb = new();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size: one full 640 row, then cut the frame short in width and height
        repeat (640 + 5) send_pixel(pick_pixel(3));
        drain_results();
        write_reg(gbv_pkg::REG_WIDTH, 4);
        write_reg(gbv_pkg::REG_HEIGHT, 3);
        send_rest_of_frame(3);

        // narrower rows mid-frame: the current row ends on the next pixel
        set_frame(1'b0, 10, 6);
        repeat (25) send_pixel(pick_pixel(3));
        drain_results();
        write_reg(gbv_pkg::REG_WIDTH, 4);
        send_rest_of_frame(3);

        set_frame(1'b0, 3, 3);
        send_rest_of_frame(0);
        set_frame(1'b1, 5, 5);
        send_rest_of_frame(0);
        set_frame(1'b1, 4, 6);
        send_rest_of_frame(3);
        set_frame(1'b0, 0, 0);
        send_rest_of_frame(1);
        set_frame(1'b1, 7, 6);
        send_rest_of_frame(2);

        // widest register value, then the row is cut short
        set_frame(1'b0, 2047, 3);
        repeat (20) send_pixel(pick_pixel(3));
        drain_results();
        write_reg(gbv_pkg::REG_WIDTH, 5);
        send_rest_of_frame(3);

        // tallest register value, then the row count lands past a lowered height
        set_frame(1'b0, 3, 4095);
        repeat (30) send_pixel(pick_pixel(3));
        drain_results();
        write_reg(gbv_pkg::REG_HEIGHT, 4);
        send_rest_of_frame(3);

        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            if (sent + QUIET_ITEMS >= target) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 2) == 0) reconfigure();
            gaps_on = $urandom_range(0, 3) != 0;
            if (sb.at_frame_start() && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, sb.eff_width() * sb.eff_height() - 1))
                    send_pixel(pick_pixel(3));
            else
                send_rest_of_frame($urandom_range(0, 7));
        end

        quiet = 1'b1;
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (END_SETTLE) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
